>>> rtl/rph_pkg.sv
// ----------------------------------------------------------------------------
// rph_pkg: shared types and constants
// request codes, readout table codes, controller states and the command and
// status groups passed between controller and datapath
// ----------------------------------------------------------------------------
package rph_pkg;

  // fixed field widths
  localparam int REQ_W  = 2;
  localparam int LEN_W  = 11;
  localparam int CODE_W = 3;
  localparam int QV_W   = 8;
  localparam int POS_W  = 10;
  localparam int TBL_W  = 3;
  localparam int IDX_W  = 16;
  localparam int VAL_W  = 64;

  // call codes A C G T N
  localparam int CALL_CODES = 5;
  localparam int CALL_AW    = 3;
  localparam int SCALAR_COUNT = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_READ_START = 2'd0,
    REQ_BASE       = 2'd1,
    REQ_QUALITY    = 2'd2,
    REQ_READOUT    = 2'd3
  } rph_req_t;

  typedef enum logic [TBL_W-1:0] {
    TBL_SCALAR = 3'd0,
    TBL_CALL   = 3'd1,
    TBL_QUAL   = 3'd2,
    TBL_LEN    = 3'd3,
    TBL_PCALL  = 3'd4,
    TBL_PQUAL  = 3'd5
  } rph_tbl_t;

  typedef enum logic [1:0] {
    SCL_READ_COUNT = 2'd0,
    SCL_BASE_TOTAL = 2'd1,
    SCL_LONGEST    = 2'd2,
    SCL_HIGHEST    = 2'd3
  } rph_scalar_t;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_LOOKUP = 2'd2,
    ST_UPDATE = 2'd3
  } rph_state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic lookup;
    logic update;
  } rph_cmd_t;

  typedef struct packed {
    logic clear_last;
  } rph_stat_t;

endpackage

>>> rtl/rph_ctrl.sv
// ----------------------------------------------------------------------------
// rph_ctrl: request sequencer
// clearing pass after reset, then accept / lookup / update per request
// ----------------------------------------------------------------------------
module rph_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rph_pkg::rph_stat_t stat,
  output rph_pkg::rph_cmd_t  cmd
);
  import rph_pkg::*;

  rph_state_t state;
  rph_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/rph_datapath.sv
// ----------------------------------------------------------------------------
// rph_datapath: counters, tables and result registers
// request latch, range checks, table memories with read-modify-write
// ----------------------------------------------------------------------------
module rph_datapath #(
  parameter int MAX_POSITIONS = 1024,
  parameter int QUAL_LEVELS   = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rph_pkg::rph_cmd_t            cmd,
  output rph_pkg::rph_stat_t           stat,
  input  logic [rph_pkg::REQ_W-1:0]    req_type,
  input  logic [rph_pkg::LEN_W-1:0]    read_length,
  input  logic [rph_pkg::CODE_W-1:0]   base_code,
  input  logic [rph_pkg::QV_W-1:0]     quality,
  input  logic [rph_pkg::POS_W-1:0]    position,
  input  logic [rph_pkg::TBL_W-1:0]    table_select,
  input  logic [rph_pkg::IDX_W-1:0]    read_index,
  output logic                         done,
  output logic [rph_pkg::VAL_W-1:0]    read_value,
  output logic                         status
);
  import rph_pkg::*;

  localparam int LEN_DEPTH   = MAX_POSITIONS + 1;
  localparam int PCALL_DEPTH = MAX_POSITIONS * CALL_CODES;
  localparam int PQUAL_DEPTH = MAX_POSITIONS * QUAL_LEVELS;
  localparam int LEN_AW      = $clog2(LEN_DEPTH);
  localparam int PCALL_AW    = $clog2(PCALL_DEPTH);
  localparam int PQUAL_AW    = $clog2(PQUAL_DEPTH);
  localparam int QUAL_AW     = $clog2(QUAL_LEVELS);

  localparam logic [31:0] MAX_POS_U = 32'(MAX_POSITIONS);
  localparam logic [31:0] CALL_U    = 32'(CALL_CODES);
  localparam logic [31:0] QLEV_U    = 32'(QUAL_LEVELS);
  localparam logic [31:0] LEN_U     = 32'(LEN_DEPTH);
  localparam logic [31:0] PCALL_U   = 32'(PCALL_DEPTH);
  localparam logic [31:0] PQUAL_U   = 32'(PQUAL_DEPTH);
  localparam logic [31:0] SCL_U     = 32'(SCALAR_COUNT);

  // latched request
  rph_req_t          req_r;
  logic [LEN_W-1:0]  len_r;
  logic [CODE_W-1:0] code_r;
  logic [QV_W-1:0]   qual_r;
  logic [POS_W-1:0]  pos_r;
  rph_tbl_t          tbl_r;
  logic [IDX_W-1:0]  idx_r;
  logic              ok_r;
  logic              ok_next;

  // scalar counters
  logic [VAL_W-1:0]   read_count;
  logic [VAL_W-1:0]   base_total;
  logic [LEN_W-1:0]   longest_read;
  logic [QUAL_AW-1:0] highest_quality;

  // table memories
  logic [VAL_W-1:0] call_mem  [CALL_CODES];
  logic [VAL_W-1:0] qual_mem  [QUAL_LEVELS];
  logic [VAL_W-1:0] len_mem   [LEN_DEPTH];
  logic [VAL_W-1:0] pcall_mem [PCALL_DEPTH];
  logic [VAL_W-1:0] pqual_mem [PQUAL_DEPTH];

  logic [VAL_W-1:0] call_rd, qual_rd, len_rd, pcall_rd, pqual_rd;

  logic [CALL_AW-1:0]  call_ra,  call_a_r,  call_wa;
  logic [QUAL_AW-1:0]  qual_ra,  qual_a_r,  qual_wa;
  logic [LEN_AW-1:0]   len_ra,   len_a_r,   len_wa;
  logic [PCALL_AW-1:0] pcall_ra, pcall_a_r, pcall_wa;
  logic [PQUAL_AW-1:0] pqual_ra, pqual_a_r, pqual_wa;
  logic call_we, qual_we, len_we, pcall_we, pqual_we;
  logic [VAL_W-1:0] call_wd, qual_wd, len_wd, pcall_wd, pqual_wd;

  logic [PQUAL_AW-1:0] clr_cnt;
  logic [31:0]         clr_w;
  logic [31:0]         len_w, pos_w, idx_w, pcall_lin, pqual_lin;
  logic                readout;
  logic                upd_ok;
  logic [VAL_W-1:0]    val_sel;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r  <= rph_req_t'(req_type);
      len_r  <= read_length;
      code_r <= base_code;
      qual_r <= quality;
      pos_r  <= position;
      tbl_r  <= rph_tbl_t'(table_select);
      idx_r  <= read_index;
    end
  end

  assign len_w     = {21'd0, len_r};
  assign pos_w     = {22'd0, pos_r};
  assign idx_w     = {16'd0, idx_r};
  assign pcall_lin = pos_w * CALL_U + {29'd0, code_r};
  assign pqual_lin = pos_w * QLEV_U + {24'd0, qual_r};
  assign readout   = (req_r == REQ_READOUT);

  // operand range checks
  always_comb begin
    ok_next = 1'b0;
    unique case (req_r)
      REQ_READ_START: ok_next = (len_w <= MAX_POS_U);
      REQ_BASE:       ok_next = ({29'd0, code_r} < CALL_U) && (pos_w < MAX_POS_U);
      REQ_QUALITY:    ok_next = ({24'd0, qual_r} < QLEV_U) && (pos_w < MAX_POS_U);
      REQ_READOUT: begin
        unique case (tbl_r)
          TBL_SCALAR: ok_next = (idx_w < SCL_U);
          TBL_CALL:   ok_next = (idx_w < CALL_U);
          TBL_QUAL:   ok_next = (idx_w < QLEV_U);
          TBL_LEN:    ok_next = (idx_w < LEN_U);
          TBL_PCALL:  ok_next = (idx_w < PCALL_U);
          TBL_PQUAL:  ok_next = (idx_w < PQUAL_U);
          default:    ok_next = 1'b0;
        endcase
      end
      default: ok_next = 1'b0;
    endcase
  end

  // lookup addresses: readout index or update entry
  assign call_ra  = readout ? idx_w[CALL_AW-1:0]  : code_r;
  assign qual_ra  = readout ? idx_w[QUAL_AW-1:0]  : qual_r[QUAL_AW-1:0];
  assign len_ra   = readout ? idx_w[LEN_AW-1:0]   : len_w[LEN_AW-1:0];
  assign pcall_ra = readout ? idx_w[PCALL_AW-1:0] : pcall_lin[PCALL_AW-1:0];
  assign pqual_ra = readout ? idx_w[PQUAL_AW-1:0] : pqual_lin[PQUAL_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      ok_r      <= ok_next;
      call_a_r  <= call_ra;
      qual_a_r  <= qual_ra;
      len_a_r   <= len_ra;
      pcall_a_r <= pcall_ra;
      pqual_a_r <= pqual_ra;
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign clr_w           = 32'(clr_cnt);
  assign stat.clear_last = (clr_cnt == PQUAL_AW'(PQUAL_DEPTH - 1));

  // write ports: zero during the sweep, increment on update
  assign upd_ok = cmd.update && ok_r;

  always_comb begin
    if (cmd.clear) begin
      call_we  = (clr_w < CALL_U);
      qual_we  = (clr_w < QLEV_U);
      len_we   = (clr_w < LEN_U);
      pcall_we = (clr_w < PCALL_U);
      pqual_we = 1'b1;
      call_wa  = clr_cnt[CALL_AW-1:0];
      qual_wa  = clr_cnt[QUAL_AW-1:0];
      len_wa   = clr_cnt[LEN_AW-1:0];
      pcall_wa = clr_cnt[PCALL_AW-1:0];
      pqual_wa = clr_cnt;
      call_wd  = '0;
      qual_wd  = '0;
      len_wd   = '0;
      pcall_wd = '0;
      pqual_wd = '0;
    end else begin
      call_we  = upd_ok && (req_r == REQ_BASE);
      pcall_we = upd_ok && (req_r == REQ_BASE);
      qual_we  = upd_ok && (req_r == REQ_QUALITY);
      pqual_we = upd_ok && (req_r == REQ_QUALITY);
      len_we   = upd_ok && (req_r == REQ_READ_START);
      call_wa  = call_a_r;
      qual_wa  = qual_a_r;
      len_wa   = len_a_r;
      pcall_wa = pcall_a_r;
      pqual_wa = pqual_a_r;
      call_wd  = call_rd + 64'd1;
      qual_wd  = qual_rd + 64'd1;
      len_wd   = len_rd + 64'd1;
      pcall_wd = pcall_rd + 64'd1;
      pqual_wd = pqual_rd + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (call_we) call_mem[call_wa] <= call_wd;
    if (cmd.lookup) call_rd <= call_mem[call_ra];
  end

  always_ff @(posedge clk) begin
    if (qual_we) qual_mem[qual_wa] <= qual_wd;
    if (cmd.lookup) qual_rd <= qual_mem[qual_ra];
  end

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_wa] <= len_wd;
    if (cmd.lookup) len_rd <= len_mem[len_ra];
  end

  always_ff @(posedge clk) begin
    if (pcall_we) pcall_mem[pcall_wa] <= pcall_wd;
    if (cmd.lookup) pcall_rd <= pcall_mem[pcall_ra];
  end

  always_ff @(posedge clk) begin
    if (pqual_we) pqual_mem[pqual_wa] <= pqual_wd;
    if (cmd.lookup) pqual_rd <= pqual_mem[pqual_ra];
  end

  // scalar counters
  always_ff @(posedge clk) begin
    if (rst) begin
      read_count      <= '0;
      base_total      <= '0;
      longest_read    <= '0;
      highest_quality <= '0;
    end else if (upd_ok) begin
      if (req_r == REQ_READ_START) begin
        read_count <= read_count + 64'd1;
        base_total <= base_total + {53'd0, len_r};
        if (len_r > longest_read) begin
          longest_read <= len_r;
        end
      end
      if (req_r == REQ_QUALITY) begin
        if (qual_r[QUAL_AW-1:0] > highest_quality) begin
          highest_quality <= qual_r[QUAL_AW-1:0];
        end
      end
    end
  end

  // readout select
  always_comb begin
    val_sel = '0;
    if (readout && ok_r) begin
      unique case (tbl_r)
        TBL_SCALAR: begin
          unique case (rph_scalar_t'(idx_r[1:0]))
            SCL_READ_COUNT: val_sel = read_count;
            SCL_BASE_TOTAL: val_sel = base_total;
            SCL_LONGEST:    val_sel = {53'd0, longest_read};
            SCL_HIGHEST:    val_sel = 64'(highest_quality);
            default:        val_sel = '0;
          endcase
        end
        TBL_CALL:  val_sel = call_rd;
        TBL_QUAL:  val_sel = qual_rd;
        TBL_LEN:   val_sel = len_rd;
        TBL_PCALL: val_sel = pcall_rd;
        TBL_PQUAL: val_sel = pqual_rd;
        default:   val_sel = '0;
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      read_value <= val_sel;
      status     <= !ok_r;
    end
  end

endmodule

>>> rtl/read_position_histogram_unit.sv
// ----------------------------------------------------------------------------
// read_position_histogram_unit: per-position call and quality statistics
// counts reads, lengths, call codes and qualities, globally and per position,
// and returns any counter on a readout request
// ----------------------------------------------------------------------------
// done pulses after the request has passed the lookup and update states
// requests do not overlap: busy stays high through the lookup/update
//   read-modify-write through the registered read port of the tables
// reset: scalars clear at once, then a clearing pass that sweeps
//   MAX_POSITIONS*QUAL_LEVELS table addresses (65536 at defaults) with busy high
// the receiver cannot stall: each result is a one-cycle done strobe
module read_position_histogram_unit #(
  parameter int MAX_POSITIONS = 1024,
  parameter int QUAL_LEVELS   = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [rph_pkg::REQ_W-1:0]  req_type,
  input  logic [rph_pkg::LEN_W-1:0]  read_length,
  input  logic [rph_pkg::CODE_W-1:0] base_code,
  input  logic [rph_pkg::QV_W-1:0]   quality,
  input  logic [rph_pkg::POS_W-1:0]  position,
  input  logic [rph_pkg::TBL_W-1:0]  table_select,
  input  logic [rph_pkg::IDX_W-1:0]  read_index,
  output logic                       done,
  output logic [rph_pkg::VAL_W-1:0]  read_value,
  output logic                       status
);
  import rph_pkg::*;

  // command and status groups between sequencer and datapath
  rph_cmd_t  cmd;
  rph_stat_t stat;

  // sequencer: clearing pass, then accept, lookup, update per request
  rph_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath: request latch, range checks, table memories, result registers
  rph_datapath #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .QUAL_LEVELS   (QUAL_LEVELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req_type),
    .read_length  (read_length),
    .base_code    (base_code),
    .quality      (quality),
    .position     (position),
    .table_select (table_select),
    .read_index   (read_index),
    .done         (done),
    .read_value   (read_value),
    .status       (status)
  );

  // an accepted request keeps the unit busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("unit not busy after accepting a request");

  // a result only follows a cycle of work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in flight");

  // one result per request: strobes never back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // a rejected request returns zero
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (read_value == 64'd0))
    else $error("rejected request returned a nonzero value");

endmodule

>>> bench/tb_read_position_histogram_unit.sv
// ----------------------------------------------------------------------------
// tb_read_position_histogram_unit: self-checking bench for the histogram unit
// a queue-fed driver issues read starts, base calls, quality values and
// counter readouts; a monitor tracks every counter the unit keeps and
// checks each done strobe against the oldest predicted result
// ----------------------------------------------------------------------------
module tb_read_position_histogram_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rph_pkg::*;

  localparam int MAX_POSITIONS = 1024;
  localparam int QUAL_LEVELS   = 64;
  localparam int LEN_DEPTH     = MAX_POSITIONS + 1;
  localparam int PCALL_DEPTH   = MAX_POSITIONS * CALL_CODES;
  localparam int PQUAL_DEPTH   = MAX_POSITIONS * QUAL_LEVELS;

  localparam int RANDOM_ITEMS  = 1300;
  localparam int IDLE_PCT      = 22;
  localparam int QUIET_FROM    = 500;   // driver never idles inside this window
  localparam int QUIET_TO      = 800;
  localparam int DRAIN_CYCLES  = 12;    // margin for the last done strobe after its accept
  // clearing pass + ~1350 requests plus gaps, many times over
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // one request as the unit sees it; table is wider than the enum (6, 7 invalid)
  typedef struct {
    rph_req_t         kind;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
    logic [QV_W-1:0]   qual;
    logic [POS_W-1:0]  pos;
    logic [TBL_W-1:0]  tbl;
    logic [IDX_W-1:0]  idx;
  } hist_req_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             status;
  } hist_res_t;

  // a counter that has seen traffic, used to aim readouts at live entries
  typedef struct {
    logic [TBL_W-1:0] tbl;
    logic [IDX_W-1:0] idx;
  } probe_t;

  // dut ports
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [REQ_W-1:0]  req_type = '0;
  logic [LEN_W-1:0]  read_length = '0;
  logic [CODE_W-1:0] base_code = '0;
  logic [QV_W-1:0]   quality = '0;
  logic [POS_W-1:0]  position = '0;
  logic [TBL_W-1:0]  table_select = '0;
  logic [IDX_W-1:0]  read_index = '0;
  logic              done;
  logic [VAL_W-1:0]  read_value;
  logic              status;

  read_position_histogram_unit #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .QUAL_LEVELS  (QUAL_LEVELS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .read_length (read_length),
    .base_code   (base_code),
    .quality     (quality),
    .position    (position),
    .table_select(table_select),
    .read_index  (read_index),
    .done        (done),
    .read_value  (read_value),
    .status      (status)
  );

  // shadow copy of every counter in the unit, all zero after reset
  bit [63:0]       n_reads;
  bit [63:0]       base_sum;
  bit [LEN_W-1:0]  max_len;
  bit [5:0]        max_qual;
  bit [63:0]       call_hist     [CALL_CODES];
  bit [63:0]       qual_hist     [QUAL_LEVELS];
  bit [63:0]       len_hist      [LEN_DEPTH];
  bit [63:0]       pos_call_hist [PCALL_DEPTH];
  bit [63:0]       pos_qual_hist [PQUAL_DEPTH];

  hist_req_t request_backlog[$];   // built up front, drained by the driver
  hist_res_t due_results[$];       // predicted results, oldest first
  probe_t    touched[$];

  int n_total;
  int n_issued;
  int n_accepted;
  int n_checked;
  int n_errors;
  int n_kind[4];
  int n_rejected;
  int n_cycles;

  // --------------------------------------------------------------------------
  // prediction: apply one accepted request to the shadow counters
  // --------------------------------------------------------------------------
  function automatic hist_res_t tally_request(hist_req_t r);
    hist_res_t res;
    res.value  = '0;
    res.status = STATUS_BAD;
    case (r.kind)
      REQ_READ_START: begin
        // lengths up to MAX_POSITIONS inclusive, zero length counts too
        if (int'(r.len) <= MAX_POSITIONS) begin
          n_reads  += 64'd1;
          base_sum += 64'(r.len);
          len_hist[r.len] += 64'd1;
          if (r.len > max_len) max_len = r.len;
          res.status = STATUS_OK;
        end
      end
      REQ_BASE: begin
        // position is not checked against the current read length
        if (int'(r.code) < CALL_CODES && int'(r.pos) < MAX_POSITIONS) begin
          call_hist[r.code] += 64'd1;
          pos_call_hist[int'(r.pos) * CALL_CODES + int'(r.code)] += 64'd1;
          res.status = STATUS_OK;
        end
      end
      REQ_QUALITY: begin
        if (int'(r.qual) < QUAL_LEVELS && int'(r.pos) < MAX_POSITIONS) begin
          qual_hist[r.qual] += 64'd1;
          pos_qual_hist[int'(r.pos) * QUAL_LEVELS + int'(r.qual)] += 64'd1;
          if (r.qual[5:0] > max_qual) max_qual = r.qual[5:0];
          res.status = STATUS_OK;
        end
      end
      default: begin
        // readout: a bad table or an index past the table end reads as zero
        case (r.tbl)
          TBL_SCALAR: begin
            res.status = STATUS_OK;
            if (r.idx == IDX_W'(SCL_READ_COUNT))      res.value = n_reads;
            else if (r.idx == IDX_W'(SCL_BASE_TOTAL)) res.value = base_sum;
            else if (r.idx == IDX_W'(SCL_LONGEST))    res.value = 64'(max_len);
            else if (r.idx == IDX_W'(SCL_HIGHEST))    res.value = 64'(max_qual);
            else res.status = STATUS_BAD;
          end
          TBL_CALL:
            if (int'(r.idx) < CALL_CODES) begin
              res.value  = call_hist[r.idx];
              res.status = STATUS_OK;
            end
          TBL_QUAL:
            if (int'(r.idx) < QUAL_LEVELS) begin
              res.value  = qual_hist[r.idx];
              res.status = STATUS_OK;
            end
          TBL_LEN:
            if (int'(r.idx) < LEN_DEPTH) begin
              res.value  = len_hist[r.idx];
              res.status = STATUS_OK;
            end
          TBL_PCALL:
            if (int'(r.idx) < PCALL_DEPTH) begin
              res.value  = pos_call_hist[r.idx];
              res.status = STATUS_OK;
            end
          TBL_PQUAL:
            if (int'(r.idx) < PQUAL_DEPTH) begin
              res.value  = pos_qual_hist[r.idx];
              res.status = STATUS_OK;
            end
          default: ;
        endcase
      end
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus building
  // --------------------------------------------------------------------------

  // every field random, so fields a request ignores still toggle
  function automatic hist_req_t any_request();
    hist_req_t r;
    r.kind = rph_req_t'(REQ_W'($urandom_range(0, 3)));
    r.len  = LEN_W'($urandom_range(0, 2047));
    r.code = CODE_W'($urandom_range(0, 7));
    r.qual = QV_W'($urandom_range(0, 255));
    r.pos  = POS_W'($urandom_range(0, 1023));
    r.tbl  = TBL_W'($urandom_range(0, 7));
    r.idx  = IDX_W'($urandom_range(0, 65535));
    return r;
  endfunction

  function automatic void note_touch(logic [TBL_W-1:0] tbl, int idx);
    probe_t p;
    p.tbl = tbl;
    p.idx = IDX_W'(idx);
    touched.push_back(p);
    if (touched.size() > 64) void'(touched.pop_front());
  endfunction

  // queue a request and remember which counters it will bump
  function automatic void queue_request(hist_req_t r);
    request_backlog.push_back(r);
    case (r.kind)
      REQ_READ_START:
        if (int'(r.len) <= MAX_POSITIONS) begin
          note_touch(TBL_LEN, int'(r.len));
          note_touch(TBL_SCALAR, $urandom_range(0, SCALAR_COUNT - 1));
        end
      REQ_BASE:
        if (int'(r.code) < CALL_CODES) begin
          note_touch(TBL_PCALL, int'(r.pos) * CALL_CODES + int'(r.code));
          note_touch(TBL_CALL, int'(r.code));
        end
      REQ_QUALITY:
        if (int'(r.qual) < QUAL_LEVELS) begin
          note_touch(TBL_PQUAL, int'(r.pos) * QUAL_LEVELS + int'(r.qual));
          note_touch(TBL_QUAL, int'(r.qual));
        end
      default: ;
    endcase
  endfunction

  function automatic void push_read(int len);
    hist_req_t r;
    r      = any_request();
    r.kind = REQ_READ_START;
    r.len  = LEN_W'(len);
    queue_request(r);
  endfunction

  function automatic void push_base(int code, int pos);
    hist_req_t r;
    r      = any_request();
    r.kind = REQ_BASE;
    r.code = CODE_W'(code);
    r.pos  = POS_W'(pos);
    queue_request(r);
  endfunction

  function automatic void push_qual(int qual, int pos);
    hist_req_t r;
    r      = any_request();
    r.kind = REQ_QUALITY;
    r.qual = QV_W'(qual);
    r.pos  = POS_W'(pos);
    queue_request(r);
  endfunction

  function automatic void push_readout(logic [TBL_W-1:0] tbl, int idx);
    hist_req_t r;
    r      = any_request();
    r.kind = REQ_READOUT;
    r.tbl  = tbl;
    r.idx  = IDX_W'(idx);
    queue_request(r);
  endfunction

  // a read: its start, then a call and a quality for each position it emits
  function automatic void add_read_stream();
    int pick;
    int len;
    int emit;
    int first;
    pick = $urandom_range(0, 99);
    if (pick < 80)      len = $urandom_range(1, 12);
    else if (pick < 90) len = $urandom_range(13, MAX_POSITIONS);
    else if (pick < 95) len = 0;
    else                len = $urandom_range(MAX_POSITIONS + 1, 2047);   // rejected read
    push_read(len);
    // long reads only send a handful of positions to keep the run short
    if (len > MAX_POSITIONS) emit = $urandom_range(0, 4);
    else if (len > 12)       emit = $urandom_range(1, 12);
    else                     emit = len;
    first = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_POSITIONS - emit) : 0;
    for (int p = 0; p < emit; p++) begin
      // about one in ten codes or qualities drawn from the whole field
      push_base(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                             : $urandom_range(0, CALL_CODES - 1),
                first + p);
      push_qual(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, QUAL_LEVELS - 1),
                first + p);
    end
  endfunction

  // readouts aimed mostly at counters that have seen traffic
  function automatic void add_readouts();
    probe_t p;
    int     n;
    n = $urandom_range(2, 4);
    for (int i = 0; i < n; i++) begin
      if (touched.size() != 0 && $urandom_range(0, 9) < 7) begin
        p = touched[$urandom_range(0, touched.size() - 1)];
        push_readout(p.tbl, int'(p.idx));
      end else if ($urandom_range(0, 1) == 0) begin
        push_readout(TBL_W'($urandom_range(0, 7)), $urandom_range(0, 65535));
      end else begin
        push_readout(TBL_W'($urandom_range(0, 7)), $urandom_range(0, 70));
      end
    end
  endfunction

  function automatic void build_stimulus();
    int directed;
    int pick;
    // directed: field extremes, every request kind, a rejection case for each kind
    push_readout(TBL_SCALAR, SCL_READ_COUNT);     // counters start at zero
    push_read(0);                                 // zero-length read counts
    push_read(MAX_POSITIONS);                     // longest legal read
    push_read(MAX_POSITIONS + 1);                 // one past the limit
    push_read(2047);                              // all length bits set
    push_base(0, 0);
    push_base(1, 1023);                           // last position of the longest legal read
    push_base(2, 512);
    push_base(3, 7);
    push_base(CALL_CODES - 1, 1023);
    push_base(CALL_CODES, 3);                     // first bad call code
    push_base(7, 1023);
    push_qual(0, 0);
    push_qual(QUAL_LEVELS - 1, 1023);
    push_qual(QUAL_LEVELS, 5);                    // first bad quality
    push_qual(255, 1023);
    push_readout(TBL_SCALAR, SCL_LONGEST);
    push_readout(TBL_SCALAR, SCL_HIGHEST);
    push_readout(TBL_SCALAR, SCALAR_COUNT);       // index past the scalars
    push_readout(3'd6, 0);                        // no such table
    push_readout(3'd7, 65535);
    push_readout(TBL_PCALL, PCALL_DEPTH - 1);
    push_readout(TBL_PCALL, PCALL_DEPTH);         // index past the table
    push_readout(TBL_PQUAL, PQUAL_DEPTH - 1);     // last entry of the widest table
    push_readout(TBL_LEN, LEN_DEPTH);
    directed = request_backlog.size();

    // random: mostly whole reads, then readouts, then raw noise
    while (request_backlog.size() < directed + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      add_read_stream();
      else if (pick < 85) add_readouts();
      else                queue_request(any_request());
    end
    n_total = request_backlog.size();
  endfunction

  // --------------------------------------------------------------------------
  // clock, reset and sequencing
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    build_stimulus();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // busy covers the clearing pass, so the driver just waits on the handshake
    while (n_accepted != n_total || due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d results from %0d requests: %0d read starts, %0d base calls,",
             n_checked, n_accepted, n_kind[REQ_READ_START], n_kind[REQ_BASE]);
    $display("%0d quality values, %0d readouts; %0d were rejected as out of range",
             n_kind[REQ_QUALITY], n_kind[REQ_READOUT], n_rejected);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop if the handshake or the results hang
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d requests accepted",
               n_cycles, n_accepted, n_total);
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driver: presents the next request, holds it while busy is high
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    hist_req_t nxt;
    logic      quiet;
    quiet = (n_issued >= QUIET_FROM) && (n_issued < QUIET_TO);
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      // the current request (if any) is taken at this edge, so move on;
      // start stays high across back-to-back requests
      if (request_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = request_backlog.pop_front();
        n_issued++;
        start        <= 1'b1;
        req_type     <= nxt.kind;
        read_length  <= nxt.len;
        base_code    <= nxt.code;
        quality      <= nxt.qual;
        position     <= nxt.pos;
        table_select <= nxt.tbl;
        read_index   <= nxt.idx;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: check the done strobe first, then predict any request taken now
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    hist_req_t seen;
    hist_res_t want;
    if (!rst) begin
      if (done) begin
        if (due_results.size() == 0) begin
          $error("result with no request outstanding: read_value %h status %b",
                 read_value, status);
          n_errors++;
        end else begin
          want = due_results.pop_front();
          n_checked++;
          if (read_value !== want.value) begin
            $error("read_value: expected %h, got %h", want.value, read_value);
            n_errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %b, got %b", want.status, status);
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        seen.kind = rph_req_t'(req_type);
        seen.len  = read_length;
        seen.code = base_code;
        seen.qual = quality;
        seen.pos  = position;
        seen.tbl  = table_select;
        seen.idx  = read_index;
        want = tally_request(seen);
        due_results.push_back(want);
        n_accepted++;
        n_kind[req_type]++;
        if (want.status == STATUS_BAD) n_rejected++;
      end
    end
  end

endmodule
